// File: sv/nss_pkg.sv
// Package for the nearest segment search block: widths, codes and types.
// Used by nearest_segment_search_core and nss_checker; depends on nothing.

package nss_pkg;

  localparam int COORD_BITS = 12;
  localparam int SEG_DEPTH  = 1024;
  localparam int IDX_W      = $clog2(SEG_DEPTH);
  localparam int CNT_W      = IDX_W + 1;

  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int SUM_W      = SQ_W + 1;
  localparam int C2_W       = 2 * SUM_W;
  localparam int CMP_W      = C2_W + SUM_W;

  localparam int PIPE_DEPTH = 6;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0] bx;
    logic [COORD_BITS-1:0] by;
  } seg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// File: sv/nearest_segment_search_core.sv
// Top level of the nearest segment search block: segment memory, scan pipeline and control.
// Depends on nss_pkg.
//
// The block holds a table of SEG_DEPTH line segments in a synchronous memory.
// The input channel (in_valid/in_ready) carries two kinds of transaction:
// a load writes the endpoints of one segment to entry in_slot and gives no
// result; a query brings a point and gives one result transaction on the
// output channel (out_valid/out_ready) with out_found and out_nearest_index.
// The configuration channel (cfg_valid/cfg_ready) writes edge_count, the
// number of entries a query scans; it is to be written only while no query runs, and the
// block itself does not enforce this. A query scans edge_count entries, limited to
// SEG_DEPTH, through a six-stage arithmetic pipeline. Its result is registered in the
// output register as the block returns to idle, and the next transaction is accepted
// from that same cycle. New entries are issued while earlier ones are still in the
// pipeline; the pace is set by the loop between the stage that multiplies against the
// current best candidate and the stage that compares and updates it.
// Items are handled one at a time; a load or a new query is accepted while an
// earlier result still waits in the output register. If the receiver stalls,
// a finished query holds its result internally until the register is free.
// Reset (rst_n low, synchronous) returns to idle, clears edge_count and drops
// out_valid; the memory contents are undefined until loaded.

module nearest_segment_search_core
  import nss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [IDX_W-1:0]      in_slot,
  input  logic [COORD_BITS-1:0] in_end1_x,
  input  logic [COORD_BITS-1:0] in_end1_y,
  input  logic [COORD_BITS-1:0] in_end2_x,
  input  logic [COORD_BITS-1:0] in_end2_y,
  input  logic [COORD_BITS-1:0] in_point_x,
  input  logic [COORD_BITS-1:0] in_point_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_found,
  output logic [IDX_W-1:0]      out_nearest_index,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_edge_count
);

  state_t state_r, state_nxt;

  logic in_acc, load_we, query_start, issue, out_load, upd;

  logic [CNT_W-1:0]      edge_count_r;
  logic [CNT_W-1:0]      lim_r;
  logic [CNT_W-1:0]      issue_cnt_r;
  logic                  phase_r;
  logic [COORD_BITS-1:0] px_r, py_r;

  seg_t mem [SEG_DEPTH];
  seg_t mem_q_r;

  logic [PIPE_DEPTH-1:0] pv_r;
  logic [IDX_W-1:0]      idx_r [PIPE_DEPTH];

  // Stage A: coordinate differences.
  logic signed [DIFF_W-1:0] a_dx_r, a_dy_r, a_rx_r, a_ry_r, a_qx_r, a_qy_r;
  // Stage B: squares and cross terms.
  logic signed [PROD_W-1:0] m_dx, m_dy, m_rx, m_ry, m_qx, m_qy, m_p1, m_p2;
  logic [SQ_W-1:0]          b_sdx_r, b_sdy_r, b_srx_r, b_sry_r, b_sqx_r, b_sqy_r;
  logic signed [PROD_W-1:0] b_p1_r, b_p2_r;
  // Stage C: squared lengths and cross magnitude.
  logic signed [PROD_W-1:0] xprod, xprod_neg;
  logic [SUM_W-1:0]         c_e2_r, c_a2_r, c_b2_r, c_cm_r;
  // Stage D: angle test and squares of cross and length.
  logic [SUM_W:0]           e2b2, e2a2;
  logic                     ang_ok;
  logic                     d_ok_r;
  logic [C2_W-1:0]          d_c2_r, d_ee_r;
  logic [SUM_W-1:0]         d_e2_r;
  // Stage E: distance test and partial products against the best candidate.
  logic                     e_elig_r;
  logic [C2_W-1:0]          e_llo_r, e_lhi_r, e_rlo_r, e_rhi_r;
  logic [C2_W-1:0]          e_c2_r;
  logic [SUM_W-1:0]         e_e2_r;
  // Stage F: compare and update.
  logic [CMP_W-1:0]         lhs, rhs;

  logic                     found_r;
  logic [C2_W-1:0]          best_c2_r;
  logic [SUM_W-1:0]         best_e2_r;
  logic [IDX_W-1:0]         best_idx_r;

  logic                     out_valid_r;
  logic                     out_found_r;
  logic [IDX_W-1:0]         out_idx_r;

  assign in_acc      = in_valid && in_ready;
  assign load_we     = in_acc && (in_kind == KIND_LOAD);
  assign query_start = in_acc && (in_kind == KIND_QUERY);
  assign cfg_ready   = 1'b1;

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_nearest_index = out_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    issue     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (in_kind == KIND_QUERY)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        issue = !phase_r && (issue_cnt_r < lim_r);
        if ((issue_cnt_r == lim_r) && (pv_r == '0)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[in_slot] <= {in_end1_x, in_end1_y, in_end2_x, in_end2_y};
    end
    if (issue) begin
      mem_q_r <= mem[issue_cnt_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_count_r <= '0;
      pv_r         <= '0;
      phase_r      <= 1'b0;
      issue_cnt_r  <= '0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        edge_count_r <= cfg_edge_count;
      end
      pv_r <= {pv_r[PIPE_DEPTH-2:0], issue};
      if (query_start) begin
        phase_r     <= 1'b0;
        issue_cnt_r <= '0;
        found_r     <= 1'b0;
      end else begin
        if (state_r == ST_SCAN) begin
          phase_r <= ~phase_r;
        end
        if (issue) begin
          issue_cnt_r <= issue_cnt_r + 1'b1;
        end
        if (upd) begin
          found_r <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_start) begin
      px_r  <= in_point_x;
      py_r  <= in_point_y;
      lim_r <= (edge_count_r > CNT_W'(SEG_DEPTH)) ? CNT_W'(SEG_DEPTH) : edge_count_r;
    end
    if (out_load) begin
      out_found_r <= found_r;
      out_idx_r   <= found_r ? best_idx_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      idx_r[0] <= issue_cnt_r[IDX_W-1:0];
    end
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      idx_r[k] <= idx_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    a_dx_r <= $signed({1'b0, mem_q_r.bx}) - $signed({1'b0, mem_q_r.ax});
    a_dy_r <= $signed({1'b0, mem_q_r.by}) - $signed({1'b0, mem_q_r.ay});
    a_rx_r <= $signed({1'b0, px_r}) - $signed({1'b0, mem_q_r.ax});
    a_ry_r <= $signed({1'b0, py_r}) - $signed({1'b0, mem_q_r.ay});
    a_qx_r <= $signed({1'b0, px_r}) - $signed({1'b0, mem_q_r.bx});
    a_qy_r <= $signed({1'b0, py_r}) - $signed({1'b0, mem_q_r.by});
  end

  always_comb begin
    m_dx = a_dx_r * a_dx_r;
    m_dy = a_dy_r * a_dy_r;
    m_rx = a_rx_r * a_rx_r;
    m_ry = a_ry_r * a_ry_r;
    m_qx = a_qx_r * a_qx_r;
    m_qy = a_qy_r * a_qy_r;
    m_p1 = a_dx_r * a_ry_r;
    m_p2 = a_dy_r * a_rx_r;
  end

  always_ff @(posedge clk) begin
    b_sdx_r <= m_dx[SQ_W-1:0];
    b_sdy_r <= m_dy[SQ_W-1:0];
    b_srx_r <= m_rx[SQ_W-1:0];
    b_sry_r <= m_ry[SQ_W-1:0];
    b_sqx_r <= m_qx[SQ_W-1:0];
    b_sqy_r <= m_qy[SQ_W-1:0];
    b_p1_r  <= m_p1;
    b_p2_r  <= m_p2;
  end

  assign xprod     = b_p1_r - b_p2_r;
  assign xprod_neg = -xprod;

  always_ff @(posedge clk) begin
    c_e2_r <= {1'b0, b_sdx_r} + {1'b0, b_sdy_r};
    c_a2_r <= {1'b0, b_srx_r} + {1'b0, b_sry_r};
    c_b2_r <= {1'b0, b_sqx_r} + {1'b0, b_sqy_r};
    c_cm_r <= xprod[PROD_W-1] ? xprod_neg[SUM_W-1:0] : xprod[SUM_W-1:0];
  end

  assign e2b2   = {1'b0, c_e2_r} + {1'b0, c_b2_r};
  assign e2a2   = {1'b0, c_e2_r} + {1'b0, c_a2_r};
  assign ang_ok = (c_e2_r != '0) && ({1'b0, c_a2_r} < e2b2) && ({1'b0, c_b2_r} < e2a2);

  always_ff @(posedge clk) begin
    d_ok_r <= ang_ok;
    d_c2_r <= c_cm_r * c_cm_r;
    d_ee_r <= c_e2_r * c_e2_r;
    d_e2_r <= c_e2_r;
  end

  always_ff @(posedge clk) begin
    e_elig_r <= d_ok_r && ({d_c2_r, 2'b00} <= {2'b00, d_ee_r});
    e_llo_r  <= d_c2_r[SUM_W-1:0] * best_e2_r;
    e_lhi_r  <= d_c2_r[C2_W-1:SUM_W] * best_e2_r;
    e_rlo_r  <= best_c2_r[SUM_W-1:0] * d_e2_r;
    e_rhi_r  <= best_c2_r[C2_W-1:SUM_W] * d_e2_r;
    e_c2_r   <= d_c2_r;
    e_e2_r   <= d_e2_r;
  end

  assign lhs = {e_lhi_r, SUM_W'(0)} + CMP_W'(e_llo_r);
  assign rhs = {e_rhi_r, SUM_W'(0)} + CMP_W'(e_rlo_r);
  assign upd = pv_r[PIPE_DEPTH-1] && e_elig_r && (!found_r || (lhs < rhs));

  always_ff @(posedge clk) begin
    if (upd) begin
      best_c2_r  <= e_c2_r;
      best_e2_r  <= e_e2_r;
      best_idx_r <= idx_r[PIPE_DEPTH-1];
    end
  end

endmodule

// File: sv/nss_checker.sv
// Port-level checker for nearest_segment_search_core, attached by the bind below.
// Depends on nss_pkg and the top level's port names.

module nss_checker
  import nss_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_kind,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_found,
  input logic [IDX_W-1:0] out_nearest_index
);

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_nearest_index))
    else $error("result changed while stalled");

  // A result without a match reports index zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_nearest_index == '0)
    else $error("nonzero index without a match");

  // Reset drops any pending result.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An accepted query occupies the block, so input is not taken in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == KIND_QUERY) |=> !in_ready)
    else $error("input taken right after a query");

  // A load transaction never produces a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == KIND_LOAD) && !out_valid |=> !out_valid)
    else $error("result appeared after a load");

endmodule

bind nearest_segment_search_core nss_checker u_nss_checker (.*);

// File: tb/nearest_segment_search_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for nearest_segment_search_core: loads segments, runs point queries
// and compares each result with an in-bench model of the nearest eligible segment search or,
// for typed queries, with a fixed answer. Depends on nss_pkg and nearest_segment_search_core.

module nearest_segment_search_core_tb;
  import nss_pkg::*;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int RANDOM_ITEMS = 580;
  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_QUERY,
    ROW_CFG
  } row_op_t;

  typedef struct packed {
    row_op_t               op;
    logic [IDX_W-1:0]      slot;
    logic [COORD_BITS-1:0] x1, y1, x2, y2;
    logic [CNT_W-1:0]      edges;
    logic                  typed;
    logic                  want_found;
    logic [IDX_W-1:0]      want_index;
  } row_t;

  typedef struct packed {
    logic                  kind;
    logic [IDX_W-1:0]      slot;
    logic [COORD_BITS-1:0] e1x, e1y, e2x, e2y, px, py;
  } item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } answer_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_kind = KIND_LOAD;
  logic [IDX_W-1:0]      in_slot = '0;
  logic [COORD_BITS-1:0] in_end1_x = '0;
  logic [COORD_BITS-1:0] in_end1_y = '0;
  logic [COORD_BITS-1:0] in_end2_x = '0;
  logic [COORD_BITS-1:0] in_end2_y = '0;
  logic [COORD_BITS-1:0] in_point_x = '0;
  logic [COORD_BITS-1:0] in_point_y = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_found;
  logic [IDX_W-1:0]      out_nearest_index;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CNT_W-1:0]      cfg_edge_count = '0;

  seg_t             seg_model [SEG_DEPTH];
  bit               seg_loaded [SEG_DEPTH];
  logic [CNT_W-1:0] edge_setting = '0;
  answer_t          pending_answers [$];
  answer_t          oldest_answer;
  row_t             directed_rows [$];
  row_t             cur_row;
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count = 0;
  int unsigned      ready_hold = 0;
  int unsigned      ready_pick;
  int unsigned      random_items;
  int unsigned      phase_span;
  int unsigned      phase_pick;
  int unsigned      slot_no;
  bit               steady_send = 1'b0;
  bit               full_table_done = 1'b0;

  nearest_segment_search_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_slot           (in_slot),
    .in_end1_x         (in_end1_x),
    .in_end1_y         (in_end1_y),
    .in_end2_x         (in_end2_x),
    .in_end2_y         (in_end2_y),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_nearest_index (out_nearest_index),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_edge_count    (cfg_edge_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned scan_length();
    return (edge_setting > SEG_DEPTH) ? SEG_DEPTH : edge_setting;
  endfunction

  // A segment qualifies when both endpoint angles are acute and its distance to the
  // point is at most half its length; a strictly smaller distance replaces the best.
  function automatic answer_t nearest_eligible(logic [COORD_BITS-1:0] qx,
                                               logic [COORD_BITS-1:0] qy);
    answer_t           ans;
    int                i;
    longint            px, py, ax, ay, bx, by, dx, dy, rx, ry, xprod;
    longint unsigned   e2, a2, b2, c2, best_c2, best_e2;
    logic [127:0]      lhs, rhs;
    ans = '0;
    best_c2 = 0;
    best_e2 = 1;
    px = qx;
    py = qy;
    for (i = 0; i < scan_length(); i++) begin
      ax = seg_model[i].ax;
      ay = seg_model[i].ay;
      bx = seg_model[i].bx;
      by = seg_model[i].by;
      dx = bx - ax;
      dy = by - ay;
      rx = px - ax;
      ry = py - ay;
      e2 = dx * dx + dy * dy;
      a2 = rx * rx + ry * ry;
      b2 = (px - bx) * (px - bx) + (py - by) * (py - by);
      if (e2 == 0 || a2 >= e2 + b2 || b2 >= e2 + a2) continue;
      xprod = dx * ry - dy * rx;
      c2 = xprod * xprod;
      if (4 * c2 > e2 * e2) continue;
      if (ans.found) begin
        lhs = c2;
        lhs = lhs * best_e2;
        rhs = best_c2;
        rhs = rhs * e2;
        if (lhs >= rhs) continue;
      end
      ans.found = 1'b1;
      ans.index = i[IDX_W-1:0];
      best_c2 = c2;
      best_e2 = e2;
    end
    return ans;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_coord(longint v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_BITS'(COORD_MAX);
    return v[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] border_coord();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return COORD_BITS'(COORD_MAX);
      2: return COORD_BITS'($urandom_range(0, 3));
      default: return COORD_BITS'(COORD_MAX - $urandom_range(0, 3));
    endcase
  endfunction

  function automatic item_t load_item(logic [IDX_W-1:0] slot, seg_t s);
    item_t it;
    it.kind = KIND_LOAD;
    it.slot = slot;
    it.e1x = s.ax;
    it.e1y = s.ay;
    it.e2x = s.bx;
    it.e2y = s.by;
    it.px = COORD_BITS'($urandom_range(0, COORD_MAX));
    it.py = COORD_BITS'($urandom_range(0, COORD_MAX));
    return it;
  endfunction

  function automatic item_t query_item(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
    item_t it;
    it.kind = KIND_QUERY;
    it.slot = IDX_W'($urandom_range(0, SEG_DEPTH - 1));
    it.e1x = COORD_BITS'($urandom_range(0, COORD_MAX));
    it.e1y = COORD_BITS'($urandom_range(0, COORD_MAX));
    it.e2x = COORD_BITS'($urandom_range(0, COORD_MAX));
    it.e2y = COORD_BITS'($urandom_range(0, COORD_MAX));
    it.px = px;
    it.py = py;
    return it;
  endfunction

  function automatic row_t load_row(int slot, int x1, int y1, int x2, int y2);
    row_t r;
    r = '0;
    r.op = ROW_LOAD;
    r.slot = IDX_W'(slot);
    r.x1 = COORD_BITS'(x1);
    r.y1 = COORD_BITS'(y1);
    r.x2 = COORD_BITS'(x2);
    r.y2 = COORD_BITS'(y2);
    return r;
  endfunction

  function automatic row_t query_row(int px, int py, bit typed, bit found, int index);
    row_t r;
    r = '0;
    r.op = ROW_QUERY;
    r.x1 = COORD_BITS'(px);
    r.y1 = COORD_BITS'(py);
    r.typed = typed;
    r.want_found = found;
    r.want_index = IDX_W'(index);
    return r;
  endfunction

  function automatic row_t cfg_row(int edges);
    row_t r;
    r = '0;
    r.op = ROW_CFG;
    r.edges = CNT_W'(edges);
    return r;
  endfunction

  function automatic seg_t random_segment(int unsigned limit);
    seg_t        s;
    int unsigned pick, span, x0, y0, src;
    pick = $urandom_range(0, 99);
    s.ax = COORD_BITS'($urandom_range(0, COORD_MAX));
    s.ay = COORD_BITS'($urandom_range(0, COORD_MAX));
    s.bx = COORD_BITS'($urandom_range(0, COORD_MAX));
    s.by = COORD_BITS'($urandom_range(0, COORD_MAX));
    if (pick < 35) begin
      span = ($urandom_range(0, 1) != 0) ? 15 : 255;
      x0 = $urandom_range(0, COORD_MAX - span);
      y0 = $urandom_range(0, COORD_MAX - span);
      s.ax = COORD_BITS'(x0 + $urandom_range(0, span));
      s.ay = COORD_BITS'(y0 + $urandom_range(0, span));
      s.bx = COORD_BITS'(x0 + $urandom_range(0, span));
      s.by = COORD_BITS'(y0 + $urandom_range(0, span));
    end else if (pick < 47) begin
      s.ax = border_coord();
      s.ay = border_coord();
      s.bx = border_coord();
      s.by = border_coord();
    end else if (pick < 57) begin
      s.bx = s.ax;
      s.by = s.ay;
    end else if (pick < 67 && limit != 0) begin
      src = $urandom_range(0, limit - 1);
      if (seg_loaded[src]) s = seg_model[src];
    end
    return s;
  endfunction

  // Points are placed along a stored segment, on the perpendicular through an endpoint
  // or the midpoint, on the border, or anywhere.
  function automatic item_t random_query(int unsigned limit);
    seg_t        s;
    longint      qx, qy, ax, ay, bx, by, ddx, ddy;
    int          pick, t, reach, k;
    pick = $urandom_range(0, 99);
    qx = $urandom_range(0, COORD_MAX);
    qy = $urandom_range(0, COORD_MAX);
    if (limit != 0 && pick < 60) begin
      s = seg_model[$urandom_range(0, limit - 1)];
      ax = s.ax;
      ay = s.ay;
      bx = s.bx;
      by = s.by;
      ddx = bx - ax;
      ddy = by - ay;
      if (pick < 40) begin
        t = $urandom_range(0, 8);
        reach = ($urandom_range(0, 1) != 0) ? 3 : 300;
        k = $urandom_range(0, 2 * reach);
        qx = ax + ddx * t / 8 + k - reach;
        k = $urandom_range(0, 2 * reach);
        qy = ay + ddy * t / 8 + k - reach;
      end else begin
        t = $urandom_range(0, 2);
        k = $urandom_range(0, 2);
        k = k - 1;
        qx = (t == 0) ? ax : (t == 1) ? bx : (ax + bx) / 2;
        qy = (t == 0) ? ay : (t == 1) ? by : (ay + by) / 2;
        qx = qx - k * ddy / 2;
        qy = qy + k * ddx / 2;
      end
    end else if (pick < 80) begin
      qx = border_coord();
      qy = border_coord();
    end
    return query_item(clamp_coord(qx), clamp_coord(qy));
  endfunction

  function automatic logic [IDX_W-1:0] random_slot(int unsigned limit);
    if (limit == 0 || $urandom_range(0, 4) == 0) return IDX_W'($urandom_range(0, SEG_DEPTH - 1));
    return IDX_W'($urandom_range(0, limit - 1));
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned pick;
    if (steady_send) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic put_item(input item_t it, input logic typed, input answer_t typed_ans);
    int unsigned gap;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= it.kind;
    in_slot <= it.slot;
    in_end1_x <= it.e1x;
    in_end1_y <= it.e1y;
    in_end2_x <= it.e2x;
    in_end2_y <= it.e2y;
    in_point_x <= it.px;
    in_point_y <= it.py;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.kind == KIND_LOAD) begin
      seg_model[it.slot] = {it.e1x, it.e1y, it.e2x, it.e2y};
      seg_loaded[it.slot] = 1'b1;
    end else begin
      pending_answers.push_back(typed ? typed_ans : nearest_eligible(it.px, it.py));
    end
  endtask

  // The sender holds off until every query has answered and the scan has had time to end.
  task automatic set_edge_count(input logic [CNT_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (2 * scan_length() + 16) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_edge_count <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    edge_setting = value;
  endtask

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 45) begin
        out_ready <= 1'b1;
        ready_hold <= $urandom_range(0, 40);
      end else if (ready_pick < 85) begin
        out_ready <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else if (ready_pick < 96) begin
        out_ready <= 1'b1;
        ready_hold <= 0;
      end else begin
        out_ready <= 1'b0;
        ready_hold <= $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("result transaction with no query outstanding: found %0d, nearest_index %0d",
               out_found, out_nearest_index);
        mismatch_count = mismatch_count + 1;
      end else begin
        oldest_answer = pending_answers.pop_front();
        if (out_found !== oldest_answer.found) begin
          $error("found: expected %0d, actual %0d", oldest_answer.found, out_found);
          mismatch_count = mismatch_count + 1;
        end
        if (out_nearest_index !== oldest_answer.index) begin
          $error("nearest_index: expected %0d, actual %0d",
                 oldest_answer.index, out_nearest_index);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run exceeded %0d cycles with %0d results outstanding",
             CYCLE_LIMIT, pending_answers.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_rows.push_back(query_row(2048, 2048, 1'b1, 1'b0, 0));
    directed_rows.push_back(load_row(0, 100, 100, 100, 100));
    directed_rows.push_back(load_row(1, 0, 0, COORD_MAX, 0));
    directed_rows.push_back(load_row(2, 0, COORD_MAX, COORD_MAX, COORD_MAX));
    directed_rows.push_back(load_row(3, COORD_MAX, COORD_MAX, 0, 0));
    directed_rows.push_back(load_row(4, 0, 0, COORD_MAX, 0));
    directed_rows.push_back(load_row(5, 2000, 1000, 2000, 1200));
    directed_rows.push_back(load_row(6, 1000, 3000, 1400, 3000));
    directed_rows.push_back(load_row(SEG_DEPTH - 1, COORD_MAX, 0, 0, COORD_MAX));
    directed_rows.push_back(cfg_row(7));
    directed_rows.push_back(query_row(2048, 1, 1'b1, 1'b1, 1));
    directed_rows.push_back(query_row(0, 0, 1'b1, 1'b0, 0));
    directed_rows.push_back(query_row(COORD_MAX, COORD_MAX, 1'b1, 1'b0, 0));
    directed_rows.push_back(query_row(1200, 3200, 1'b0, 1'b0, 0));
    directed_rows.push_back(query_row(1200, 3201, 1'b0, 1'b0, 0));
    directed_rows.push_back(query_row(100, 100, 1'b0, 1'b0, 0));
    directed_rows.push_back(query_row(COORD_MAX, 0, 1'b0, 1'b0, 0));
    directed_rows.push_back(cfg_row(1));
    directed_rows.push_back(query_row(100, 100, 1'b1, 1'b0, 0));
    directed_rows.push_back(cfg_row(0));
    directed_rows.push_back(query_row(COORD_MAX, 0, 1'b1, 1'b0, 0));

    foreach (directed_rows[r]) begin
      cur_row = directed_rows[r];
      case (cur_row.op)
        ROW_CFG: begin
          set_edge_count(cur_row.edges);
        end
        ROW_LOAD: begin
          put_item(load_item(cur_row.slot, {cur_row.x1, cur_row.y1, cur_row.x2, cur_row.y2}),
                   1'b0, '0);
        end
        default: begin
          put_item(query_item(cur_row.x1, cur_row.y1), cur_row.typed,
                   {cur_row.want_found, cur_row.want_index});
        end
      endcase
    end

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (!full_table_done && random_items >= RANDOM_ITEMS / 2) begin
        full_table_done = 1'b1;
        steady_send = 1'b0;
        for (slot_no = 0; slot_no < SEG_DEPTH; slot_no++) begin
          if (!seg_loaded[slot_no]) begin
            put_item(load_item(IDX_W'(slot_no), random_segment(SEG_DEPTH)), 1'b0, '0);
            random_items++;
          end
        end
        set_edge_count(CNT_W'(SEG_DEPTH));
        repeat (3) begin
          put_item(random_query(SEG_DEPTH), 1'b0, '0);
          random_items++;
        end
        set_edge_count({CNT_W{1'b1}});
        repeat (2) begin
          put_item(random_query(SEG_DEPTH), 1'b0, '0);
          random_items++;
        end
      end

      steady_send = ($urandom_range(0, 3) == 0);
      phase_pick = $urandom_range(0, 99);
      if (phase_pick < 7) phase_span = 0;
      else if (phase_pick < 75) phase_span = $urandom_range(1, 12);
      else if (phase_pick < 96) phase_span = $urandom_range(13, 48);
      else phase_span = $urandom_range(49, 160);

      for (slot_no = 0; slot_no < phase_span; slot_no++) begin
        if (!seg_loaded[slot_no]) begin
          put_item(load_item(IDX_W'(slot_no), random_segment(phase_span)), 1'b0, '0);
          random_items++;
        end
      end
      repeat ($urandom_range(0, phase_span / 2 + 2)) begin
        put_item(load_item(random_slot(phase_span), random_segment(phase_span)), 1'b0, '0);
        random_items++;
      end
      set_edge_count(CNT_W'(phase_span));
      repeat ($urandom_range(6, 16)) begin
        if ($urandom_range(0, 4) == 0) begin
          put_item(load_item(random_slot(phase_span), random_segment(phase_span)), 1'b0, '0);
        end else begin
          put_item(random_query(phase_span), 1'b0, '0);
        end
        random_items++;
      end
    end

    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (2 * scan_length() + 16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/nss_pkg.sv
sv/nearest_segment_search_core.sv
sv/nss_checker.sv
tb/nearest_segment_search_core_tb.sv
